// ----- design/rdd_pkg.sv -----
// Shared types and constants for the resource deadlock detector.
package rdd_pkg;

    localparam int PC_BITS       = 5;
    localparam int RC_BITS       = 4;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 5;

    localparam logic [PC_BITS-1:0] PC_RESET = 5'd16;
    localparam logic [RC_BITS-1:0] RC_RESET = 4'd8;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PROCESS_COUNT  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RESOURCE_COUNT = 1'b1;

    typedef enum logic [1:0] {
        ACT_LOAD_HELD   = 2'd0,
        ACT_LOAD_WANTED = 2'd1,
        ACT_LOAD_FREE   = 2'd2,
        ACT_RUN         = 2'd3
    } action_t;

    typedef struct packed {
        action_t     action;
        logic [3:0]  process_index;
        logic [2:0]  resource_index;
        logic [15:0] amount;
    } rdd_in_t;

    typedef struct packed {
        logic       deadlocked;
        logic [3:0] process_id;
        logic       last;
    } rdd_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_PROC,
        ST_FIT_RD,
        ST_FIT_CMP,
        ST_REL_RD,
        ST_REL_ADD,
        ST_EMIT
    } rdd_state_t;

endpackage

// ----- design/rdd_matrix.sv -----
// Allocation and request matrix storage with one write port and one registered read port.
module rdd_matrix #(
    parameter int DEPTH     = 128,
    parameter int AW        = 7,
    parameter int UNIT_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 held_we,
    input  logic                 wanted_we,
    input  logic [AW-1:0]        wr_addr,
    input  logic [UNIT_BITS-1:0] wr_data,
    input  logic [AW-1:0]        rd_addr,
    output logic [UNIT_BITS-1:0] held_q,
    output logic [UNIT_BITS-1:0] wanted_q
);

    logic [UNIT_BITS-1:0] held_mem   [DEPTH];
    logic [UNIT_BITS-1:0] wanted_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (held_we) begin
            held_mem[wr_addr] <= wr_data;
        end
        held_q <= held_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (wanted_we) begin
            wanted_mem[wr_addr] <= wr_data;
        end
        wanted_q <= wanted_mem[rd_addr];
    end

endmodule

// ----- design/resource_deadlock_detector.sv -----
// Top level of the resource deadlock detector: sequencer, work vector and result register.
//
//   channel   direction  handshake               payload
//   s_        in         s_valid / s_ready       rdd_in_t  (action, indexes, amount)
//   m_        out        m_valid / m_ready       rdd_out_t (deadlocked, process_id, last)
//   cfg_      in         cfg_we, no wait         cfg_index, cfg_data
//
// A load transfer leaves the block idle, so it stays ready for another transfer.
// A run transfer starts with a setup step (ST_START). Each pass then visits every
// process row (ST_PROC), compares each resource of an unfinished row (ST_FIT_RD, then
// ST_FIT_CMP), releases each resource of a row that fits (ST_REL_RD, then ST_REL_ADD),
// all through the single matrix read port; passes repeat until one marks no process
// finished. Reporting walks the rows in turn and then gives the final result.
// Reset is synchronous on aresetn low and needs no clearing pass.
// Results wait in the output register while m_ready is low; the walk then stalls at an unfinished process.
module resource_deadlock_detector #(
    parameter int MAX_PROCS = 16,
    parameter int MAX_RES   = 8,
    parameter int UNIT_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  rdd_pkg::rdd_in_t                     s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output rdd_pkg::rdd_out_t                    m_data,
    input  logic                                 cfg_we,
    input  logic [rdd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [rdd_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    import rdd_pkg::*;

    // Work counters are four bits wider than a unit count and saturate.
    localparam int WORK_BITS = UNIT_BITS + 4;
    localparam int SUM_BITS  = WORK_BITS + 1;
    localparam int DEPTH     = MAX_PROCS * MAX_RES;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW        = $clog2(MAX_PROCS + 1);
    localparam int PIW       = $clog2(MAX_PROCS);
    localparam int KW        = $clog2(MAX_RES + 1);
    localparam int RIW       = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
    localparam int PCW       = (PW > PC_BITS) ? PW : PC_BITS;
    localparam int RCW       = (KW > RC_BITS) ? KW : RC_BITS;

    rdd_state_t state_reg, state_next;

    logic [PC_BITS-1:0]   process_count_reg;
    logic [RC_BITS-1:0]   resource_count_reg;

    logic [UNIT_BITS-1:0] free_reg [MAX_RES];
    logic [WORK_BITS-1:0] work_reg [MAX_RES];
    logic [MAX_PROCS-1:0] done_reg;

    logic [PW-1:0]        proc_reg;
    logic [KW-1:0]        k_reg;
    logic [AW-1:0]        base_reg;
    logic                 progress_reg;
    logic                 pend_valid_reg;
    logic [PIW-1:0]       pend_id_reg;
    logic                 m_valid_reg;
    rdd_out_t             m_data_reg;

    logic [PW-1:0]        np;
    logic [KW-1:0]        nr;
    logic                 proc_at_end;
    logic                 k_at_end;
    logic                 done_cur;
    logic [WORK_BITS-1:0] work_cur;
    logic                 too_big;
    logic [SUM_BITS-1:0]  sum;
    logic [WORK_BITS-1:0] sum_sat;
    logic                 out_free;
    logic                 push;
    rdd_out_t             push_data;

    logic                 accept;
    logic                 row_ok;
    logic                 col_ok;
    logic                 held_we;
    logic                 wanted_we;
    logic [AW-1:0]        wr_addr;
    logic [UNIT_BITS-1:0] wr_data;
    logic [AW-1:0]        rd_addr;
    logic [UNIT_BITS-1:0] held_q;
    logic [UNIT_BITS-1:0] wanted_q;

    // Effective counts: a configured count above the array size uses the array size.
    always_comb begin
        if (PCW'(process_count_reg) > PCW'(MAX_PROCS)) begin
            np = PW'(MAX_PROCS);
        end else begin
            np = PW'(process_count_reg);
        end
        if (RCW'(resource_count_reg) > RCW'(MAX_RES)) begin
            nr = KW'(MAX_RES);
        end else begin
            nr = KW'(resource_count_reg);
        end
    end

    assign proc_at_end = (proc_reg == np);
    assign k_at_end    = (k_reg == nr);
    assign done_cur    = done_reg[proc_reg[PIW-1:0]];
    assign work_cur    = work_reg[k_reg[RIW-1:0]];

    // The one shared compare and saturating adder of the sweep.
    assign too_big = WORK_BITS'(wanted_q) > work_cur;
    assign sum     = SUM_BITS'(work_cur) + SUM_BITS'(held_q);
    assign sum_sat = sum[WORK_BITS] ? '1 : sum[WORK_BITS-1:0];

    assign out_free = !m_valid_reg || m_ready;

    // Load transfers go straight into storage; loads with an index beyond the arrays
    // are dropped.
    assign accept    = s_valid && s_ready;
    assign row_ok    = int'(s_data.process_index) < MAX_PROCS;
    assign col_ok    = int'(s_data.resource_index) < MAX_RES;
    assign held_we   = accept && (s_data.action == ACT_LOAD_HELD) && row_ok && col_ok;
    assign wanted_we = accept && (s_data.action == ACT_LOAD_WANTED) && row_ok && col_ok;
    assign wr_addr   = AW'(int'(s_data.process_index) * MAX_RES
                           + int'(s_data.resource_index));
    assign wr_data   = UNIT_BITS'(s_data.amount);
    assign rd_addr   = base_reg + AW'(k_reg);

    rdd_matrix #(
        .DEPTH     (DEPTH),
        .AW        (AW),
        .UNIT_BITS (UNIT_BITS)
    ) u_matrix (
        .aclk      (aclk),
        .held_we   (held_we),
        .wanted_we (wanted_we),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .held_q    (held_q),
        .wanted_q  (wanted_q)
    );

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && (s_data.action == ACT_RUN)) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                state_next = ST_PROC;
            end
            ST_PROC: begin
                if (proc_at_end) begin
                    state_next = progress_reg ? ST_PROC : ST_EMIT;
                end else if (!done_cur) begin
                    state_next = ST_FIT_RD;
                end
            end
            ST_FIT_RD: begin
                state_next = k_at_end ? ST_REL_RD : ST_FIT_CMP;
            end
            ST_FIT_CMP: begin
                state_next = too_big ? ST_PROC : ST_FIT_RD;
            end
            ST_REL_RD: begin
                state_next = k_at_end ? ST_PROC : ST_REL_ADD;
            end
            ST_REL_ADD: begin
                state_next = ST_REL_RD;
            end
            ST_EMIT: begin
                if (proc_at_end && out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs. While reporting, one unfinished process is held back so
    // that the last flag can be set on it once the walk reaches the end.
    always_comb begin
        s_ready   = 1'b0;
        push      = 1'b0;
        push_data = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_EMIT: begin
                if (proc_at_end) begin
                    push                 = out_free;
                    push_data.deadlocked = pend_valid_reg;
                    push_data.process_id = pend_valid_reg ? 4'(pend_id_reg) : 4'd0;
                    push_data.last       = 1'b1;
                end else if (!done_cur && pend_valid_reg) begin
                    push                 = out_free;
                    push_data.deadlocked = 1'b1;
                    push_data.process_id = 4'(pend_id_reg);
                    push_data.last       = 1'b0;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            process_count_reg  <= PC_RESET;
            resource_count_reg <= RC_RESET;
            progress_reg       <= 1'b0;
            pend_valid_reg     <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_PROCESS_COUNT:  process_count_reg  <= cfg_data[PC_BITS-1:0];
                    CFG_RESOURCE_COUNT: resource_count_reg <= cfg_data[RC_BITS-1:0];
                    default: begin
                    end
                endcase
            end
            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_START: begin
                    progress_reg   <= 1'b0;
                    pend_valid_reg <= 1'b0;
                end
                ST_PROC: begin
                    if (proc_at_end) begin
                        progress_reg <= 1'b0;
                    end
                end
                ST_REL_RD: begin
                    if (k_at_end) begin
                        progress_reg <= 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (!proc_at_end && !done_cur && (!pend_valid_reg || out_free)) begin
                        pend_valid_reg <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath: counters, work vector, finished marks and the available vector.
    always_ff @(posedge aclk) begin
        if (accept && (s_data.action == ACT_LOAD_FREE) && col_ok) begin
            free_reg[RIW'(s_data.resource_index)] <= wr_data;
        end
        if (push) begin
            m_data_reg <= push_data;
        end
        unique case (state_reg)
            ST_START: begin
                for (int i = 0; i < MAX_RES; i++) begin
                    work_reg[i] <= WORK_BITS'(free_reg[i]);
                end
                done_reg <= '0;
                proc_reg <= '0;
                base_reg <= '0;
            end
            ST_PROC: begin
                k_reg <= '0;
                if (proc_at_end) begin
                    proc_reg <= '0;
                    base_reg <= '0;
                end else if (done_cur) begin
                    proc_reg <= proc_reg + 1'b1;
                    base_reg <= base_reg + AW'(MAX_RES);
                end
            end
            ST_FIT_RD: begin
                if (k_at_end) begin
                    k_reg <= '0;
                end
            end
            ST_FIT_CMP: begin
                if (too_big) begin
                    proc_reg <= proc_reg + 1'b1;
                    base_reg <= base_reg + AW'(MAX_RES);
                end else begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            ST_REL_RD: begin
                if (k_at_end) begin
                    done_reg[proc_reg[PIW-1:0]] <= 1'b1;
                    proc_reg <= proc_reg + 1'b1;
                    base_reg <= base_reg + AW'(MAX_RES);
                end
            end
            ST_REL_ADD: begin
                work_reg[k_reg[RIW-1:0]] <= sum_sat;
                k_reg <= k_reg + 1'b1;
            end
            ST_EMIT: begin
                if (!proc_at_end) begin
                    if (done_cur) begin
                        proc_reg <= proc_reg + 1'b1;
                    end else if (!pend_valid_reg || out_free) begin
                        pend_id_reg <= proc_reg[PIW-1:0];
                        proc_reg    <= proc_reg + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
